// File: rtl/core/tbsc_pkg.sv
// Shared types and constants for the three-register byte stream cipher.
// Used by the front queue, the back end and the top level.
package tbsc_pkg;

  localparam int unsigned FirstLen    = 7;
  localparam int unsigned SecondLen   = 9;
  localparam int unsigned ThirdLen    = 11;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam logic [7:0]  TapConst    = 8'h01;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_FIRST       = 3'd0,
    CFG_KEY_SECOND_LOW  = 3'd1,
    CFG_KEY_SECOND_HIGH = 3'd2,
    CFG_KEY_THIRD_LOW   = 3'd3,
    CFG_KEY_THIRD_HIGH  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [FirstLen-1:0][7:0]  first;
    logic [SecondLen-1:0][7:0] second;
    logic [ThirdLen-1:0][7:0]  third;
  } keys_t;

endpackage

// File: rtl/core/tbsc_front.sv
// Front queue: accepts input words and holds them until the back end pops them.
// Depends on tbsc_pkg for the queued word type.
module tbsc_front import tbsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  output logic  item_valid_o,
  input  logic  item_pop_i,
  output item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop, full;

  assign full         = (cnt_q == CntW'(Depth));
  assign in_stall_o   = full;
  assign push         = in_valid_i && !full;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_pop_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/tbsc_back.sv
// Back end: steps the three shift registers and forms the keystream in two stages.
// Depends on tbsc_pkg for the word and key types.
module tbsc_back import tbsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  input  keys_t      keys_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_out_o
);

  logic [FirstLen-1:0][7:0]  first_q, first_src, first_d;
  logic [SecondLen-1:0][7:0] second_q, second_src, second_d;
  logic [ThirdLen-1:0][7:0]  third_q, third_src, third_d;

  logic        s1_valid_q, out_valid_q;
  logic [7:0]  s1_a_q, s1_p_q, s1_data_q, out_data_q;
  logic        s1_load, s2_load, pop;
  logic [15:0] p_prod, t_prod;
  logic [7:0]  t_byte;

  assign s2_load    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || s2_load;
  assign pop        = s1_load && item_valid_i;
  assign item_pop_o = s1_load;

  // Reload from the keys before the step when the word asks for it.
  always_comb begin
    first_src  = item_i.restart ? keys_i.first  : first_q;
    second_src = item_i.restart ? keys_i.second : second_q;
    third_src  = item_i.restart ? keys_i.third  : third_q;

    for (int i = 0; i < FirstLen - 1; i++) first_d[i] = first_src[i+1];
    first_d[FirstLen-1] = first_src[0] ^ first_src[2] ^ first_src[4] ^ TapConst;
    for (int i = 0; i < SecondLen - 1; i++) second_d[i] = second_src[i+1];
    second_d[SecondLen-1] = second_src[2] ^ second_src[4] ^ second_src[6] ^ TapConst;
    for (int i = 0; i < ThirdLen - 1; i++) third_d[i] = third_src[i+1];
    third_d[ThirdLen-1] = third_src[4] ^ third_src[6] ^ third_src[8] ^ TapConst;
  end

  // a*b*c + a*b + a*c + 1 = a*((b+1)*(c+1) - 1) + 1, mod 256
  assign p_prod = {8'd0, second_src[0] + 8'd1} * {8'd0, third_src[0] + 8'd1};
  assign t_prod = {8'd0, s1_a_q} * {8'd0, s1_p_q - 8'd1};
  assign t_byte = t_prod[7:0] + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      second_q    <= '0;
      third_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        first_q  <= first_d;
        second_q <= second_d;
        third_q  <= third_d;
      end
      if (s1_load) begin
        s1_valid_q <= item_valid_i;
      end
      if (s2_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_a_q    <= first_src[0];
      s1_p_q    <= p_prod[7:0];
      s1_data_q <= item_i.data;
    end
    if (s2_load && s1_valid_q) begin
      out_data_q <= s1_data_q ^ t_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

endmodule

// File: rtl/core/three_register_byte_stream_cipher.sv
// Three-register byte stream cipher, top level: key registers, front queue, back end.
// Depends on tbsc_pkg, tbsc_front and tbsc_back.
//
// Usage:
//   Input channel in_valid_i/in_stall_o carries one word: data_in_i and restart_i.
//   A word is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel out_valid_o/out_stall_i carries data_out_o, one per input word,
//   in order. data_out_o is data_in_i XOR the keystream byte, so the same
//   stream both encrypts and decrypts.
//   The key registers are written through cfg_we_i/cfg_idx_i/cfg_data_i only
//   while idle, a rule the user must keep: the block does not enforce it. A new
//   key takes effect at the next word with restart_i set. A word passes the
//   queue, the s1 register and the output register in turn. Throughput: one word
//   per cycle while the output is not stalled. The queue holds Depth words, so
//   input keeps flowing while the receiver stalls until the queue and both stages
//   fill. Reset clears the keys and the shift registers to zero and empties the
//   queue; the registers are not loaded from the keys until a restart.
module three_register_byte_stream_cipher import tbsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_in_i,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          data_out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [55:0] key_first_q;
  logic [63:0] key_second_low_q;
  logic [7:0]  key_second_high_q;
  logic [63:0] key_third_low_q;
  logic [23:0] key_third_high_q;

  item_t in_item, q_item;
  logic  q_valid, q_pop;
  keys_t keys;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q       <= '0;
      key_second_low_q  <= '0;
      key_second_high_q <= '0;
      key_third_low_q   <= '0;
      key_third_high_q  <= '0;
    end else if (cfg_we_i) begin
      // drop writes to unknown indexes
      case (cfg_idx_i)
        CFG_KEY_FIRST:       key_first_q       <= cfg_data_i[55:0];
        CFG_KEY_SECOND_LOW:  key_second_low_q  <= cfg_data_i;
        CFG_KEY_SECOND_HIGH: key_second_high_q <= cfg_data_i[7:0];
        CFG_KEY_THIRD_LOW:   key_third_low_q   <= cfg_data_i;
        CFG_KEY_THIRD_HIGH:  key_third_high_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign keys.first  = key_first_q;
  assign keys.second = {key_second_high_q, key_second_low_q};
  assign keys.third  = {key_third_high_q, key_third_low_q};

  assign in_item.data    = data_in_i;
  assign in_item.restart = restart_i;

  tbsc_front #(
    .Depth(Depth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .item_valid_o(q_valid),
    .item_pop_i  (q_pop),
    .item_o      (q_item)
  );

  tbsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .keys_i      (keys),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o)
  );

endmodule
